@@ rtl/core/c3zp_pkg.sv @@
// Package for the 3x3 zero-padded convolution stream.
// Shared widths, config register codes and pipeline payload types.
// No dependencies.
package c3zp_pkg;

  localparam int PIX_W       = 8;
  localparam int COEF_W      = 8;
  localparam int PROD_W      = PIX_W + COEF_W + 1;
  localparam int FILT_W      = 20;
  localparam int ROW_W       = 12;
  localparam int OUT_COL_W   = 10;
  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int KROW_W      = 3 * COEF_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = KROW_W;
  localparam int MAX_HEIGHT  = 4096;
  localparam int LIM_W       = 14;
  localparam int N_SLOTS     = 4;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 48;

  // Result slots of one pixel, in emission order; slot = 2*row_shift + col_shift
  localparam int SLOT_DIAG = 0;  // (r-1, c-1)
  localparam int SLOT_UP   = 1;  // (r-1, c)
  localparam int SLOT_LEFT = 2;  // (r, c-1)
  localparam int SLOT_HERE = 3;  // (r, c)

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_KERNEL_TOP   = 3'd2,
    CFG_KERNEL_MID   = 3'd3,
    CFG_KERNEL_BOT   = 3'd4
  } cfg_reg_t;

  typedef logic [2:0][KROW_W-1:0]        kernel_t;
  typedef logic [2:0][2:0][PIX_W-1:0]    win_t;
  typedef logic [N_SLOTS-1:0][FILT_W-1:0] sums_t;

  // Output positions and which slots fire
  typedef struct packed {
    logic [N_SLOTS-1:0]   mask;
    logic [ROW_W-1:0]     row_up;
    logic [ROW_W-1:0]     row_cur;
    logic [OUT_COL_W-1:0] col_left;
    logic [OUT_COL_W-1:0] col_cur;
  } pos_t;

  // Line buffer controls for one pixel
  typedef struct packed {
    logic row_ge1;
    logic row_ge2;
    logic first_col;
  } lb_ctl_t;

endpackage

@@ rtl/core/c3zp_line_buf.sv @@
// Line buffer: one dual-row memory (read, modify, write back) and the 3x3 window.
// Depends on c3zp_pkg.
module c3zp_line_buf #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [c3zp_pkg::PIX_W-1:0]    in_pix,
  input  logic [$clog2(MAX_WIDTH)-1:0]  in_col,
  input  c3zp_pkg::lb_ctl_t             in_ctl,
  input  c3zp_pkg::pos_t                in_pos,
  output logic                          win_valid,
  input  logic                          win_ready,
  output c3zp_pkg::win_t                win,
  output c3zp_pkg::pos_t                win_pos
);
  import c3zp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // entry = {upper row pixel, lower row pixel}
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] mem_q;

  logic               s1_valid;
  logic [PIX_W-1:0]   s1_pix;
  logic [CW-1:0]      s1_col;
  lb_ctl_t            s1_ctl;
  pos_t               s1_pos;
  logic               fwd;
  logic [2*PIX_W-1:0] fwd_data;

  logic               s2_valid;
  logic               s2_ready;
  logic               s1_adv;
  logic               accept;
  logic [2*PIX_W-1:0] entry;
  logic [PIX_W-1:0]   up_pix;
  logic [PIX_W-1:0]   lo_pix;
  logic               wr_en;
  logic [2*PIX_W-1:0] wr_data;

  assign s2_ready = !s2_valid || win_ready;
  assign s1_adv   = s1_valid && s2_ready;
  assign in_ready = !s1_valid || s2_ready;
  assign accept   = in_valid && in_ready;

  // write-back of the previous pixel may hit the address read this cycle
  assign entry   = fwd ? fwd_data : mem_q;
  assign up_pix  = s1_ctl.row_ge2 ? entry[2*PIX_W-1:PIX_W] : '0;
  assign lo_pix  = s1_ctl.row_ge1 ? entry[PIX_W-1:0] : '0;
  assign wr_en   = s1_adv;
  assign wr_data = {entry[PIX_W-1:0], s1_pix};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_col] <= wr_data;
    end
    if (accept) begin
      mem_q    <= mem[in_col];
      fwd      <= wr_en && (s1_col == in_col);
      fwd_data <= wr_data;
      s1_pix   <= in_pix;
      s1_col   <= in_col;
      s1_ctl   <= in_ctl;
      s1_pos   <= in_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // window shifts left; a new row clears the two older columns
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      win      <= '0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
      for (int p = 0; p < 3; p++) begin
        win[p][0] <= s1_ctl.first_col ? '0 : win[p][1];
        win[p][1] <= s1_ctl.first_col ? '0 : win[p][2];
      end
      win[0][2] <= up_pix;
      win[1][2] <= lo_pix;
      win[2][2] <= s1_pix;
    end else if (win_ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_pos <= s1_pos;
    end
  end

  assign win_valid = s2_valid;

endmodule

@@ rtl/core/c3zp_mac.sv @@
// Multiply-accumulate stages: registered products for all four window shifts,
// then registered sums. Depends on c3zp_pkg.
module c3zp_mac (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  c3zp_pkg::win_t      win,
  input  c3zp_pkg::pos_t      in_pos,
  input  c3zp_pkg::kernel_t   kernel,
  output logic                out_valid,
  input  logic                out_ready,
  output c3zp_pkg::sums_t     sums,
  output c3zp_pkg::pos_t      out_pos
);
  import c3zp_pkg::*;

  logic signed [PROD_W-1:0] prod [N_SLOTS][9];
  logic                     p_valid;
  pos_t                     p_pos;
  logic                     s_valid;
  logic                     s_ready;
  logic                     p_load;
  logic                     s_load;
  sums_t                    sums_next;

  assign s_ready  = !s_valid || out_ready;
  assign in_ready = !p_valid || s_ready;
  assign p_load   = in_valid && in_ready;
  assign s_load   = p_valid && s_ready;

  // slot s looks at the window moved down by s/2 rows and right by s%2 columns
  for (genvar gs = 0; gs < N_SLOTS; gs++) begin : g_slot
    for (genvar gp = 0; gp < 3; gp++) begin : g_row
      for (genvar gq = 0; gq < 3; gq++) begin : g_col
        localparam int DR = gs / 2;
        localparam int DC = gs % 2;
        if (gp + DR <= 2 && gq + DC <= 2) begin : g_tap
          always_ff @(posedge clk) begin
            if (p_load) begin
              prod[gs][gp*3+gq] <= $signed({1'b0, win[gp+DR][gq+DC]})
                                 * $signed(kernel[gp][gq*COEF_W +: COEF_W]);
            end
          end
        end else begin : g_pad
          always_ff @(posedge clk) begin
            if (p_load) begin
              prod[gs][gp*3+gq] <= '0;
            end
          end
        end
      end
    end
  end

  always_comb begin
    for (int s = 0; s < N_SLOTS; s++) begin
      sums_next[s] = '0;
      for (int i = 0; i < 9; i++) begin
        sums_next[s] = sums_next[s]
                     + {{(FILT_W-PROD_W){prod[s][i][PROD_W-1]}}, prod[s][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_load) begin
      p_pos <= in_pos;
    end
    if (s_load) begin
      sums    <= sums_next;
      out_pos <= p_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      s_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        p_valid <= in_valid;
      end
      if (s_ready) begin
        s_valid <= p_valid;
      end
    end
  end

  assign out_valid = s_valid;

endmodule

@@ rtl/core/c3zp_emit.sv @@
// Result emitter: holds the group of up to four results of one pixel and sends them
// one per cycle while out_ready is high via an output register. Depends on c3zp_pkg.
module c3zp_emit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  c3zp_pkg::sums_t                   in_sums,
  input  c3zp_pkg::pos_t                    in_pos,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [c3zp_pkg::OUT_DATA_W-1:0]   out_data,
  output logic                              out_last,
  output logic                              out_flag
);
  import c3zp_pkg::*;

  logic [N_SLOTS-1:0] grp_mask;
  sums_t              grp_sums;
  pos_t               grp_pos;
  logic [1:0]         sel;
  logic [N_SLOTS-1:0] rem;
  logic               pop;
  logic [ROW_W-1:0]     sel_row;
  logic [OUT_COL_W-1:0] sel_col;

  // lowest pending slot goes first
  always_comb begin
    if (grp_mask[SLOT_DIAG]) begin
      sel = 2'(SLOT_DIAG);
    end else if (grp_mask[SLOT_UP]) begin
      sel = 2'(SLOT_UP);
    end else if (grp_mask[SLOT_LEFT]) begin
      sel = 2'(SLOT_LEFT);
    end else begin
      sel = 2'(SLOT_HERE);
    end
  end

  assign rem      = grp_mask & ~(N_SLOTS'(1) << sel);
  assign pop      = (grp_mask != '0) && (!out_valid || out_ready);
  assign in_ready = (grp_mask == '0) || (pop && rem == '0);
  assign sel_row  = sel[1] ? grp_pos.row_cur : grp_pos.row_up;
  assign sel_col  = sel[0] ? grp_pos.col_cur : grp_pos.col_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_mask <= '0;
    end else if (in_ready) begin
      grp_mask <= in_valid ? in_pos.mask : '0;
    end else if (pop) begin
      grp_mask <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      grp_sums <= in_sums;
      grp_pos  <= in_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // tdata: filtered, out_row, out_col from bit 0 up, zero padded
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= {(OUT_DATA_W-FILT_W-ROW_W-OUT_COL_W)'(0), sel_col, sel_row, grp_sums[sel]};
      out_last <= (rem == '0);
      out_flag <= (sel == 2'(SLOT_HERE));
    end
  end

endmodule

@@ rtl/core/conv3x3_zero_pad_stream.sv @@
// Top level of the 3x3 zero-padded convolution stream: config registers,
// raster counters and the pipeline. Depends on c3zp_pkg, c3zp_line_buf,
// c3zp_mac and c3zp_emit.
//
// Usage:
//  - s_tdata[7:0] carries one unsigned pixel per transaction, raster order.
//  - Each result transaction carries the 3x3 weighted sum (kernel not flipped,
//    outside pixels zero) with its row and column. m_tlast marks the last result
//    caused by a pixel, m_tuser the result for the bottom-right position.
//  - Results of the right column and the last row go out as soon as the pixel
//    that completes them arrives, so output is not in strict raster order.
//  - Config writes (cfg_wr_en, cfg_index, cfg_data) take effect at once; write
//    only while no pixel is in flight. Unknown indexes are ignored.
//  - Path: the first result of a pixel passes the memory read, window, products,
//    sums, emitter group and output registers, in order, to reach m_tvalid.
//  - Throughput: one pixel per cycle while m_tready is high and each pixel yields
//    at most one result. A pixel's results leave in turn via the single output
//    register, so the right column and last row back-pressure s_tready.
//  - Reset: counters return to the top-left, window cleared, width and height
//    1024, kernel zero. The line memory is not cleared; row 0 and 1 reads are
//    masked off instead, so no clearing pass is needed.
//  - m_tready low stalls the pipeline stage by stage; s_tready drops only once
//    every stage holds an item.
module conv3x3_zero_pad_stream #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [c3zp_pkg::IN_DATA_W-1:0]      s_tdata,   // [7:0] pixel
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [c3zp_pkg::OUT_DATA_W-1:0]     m_tdata,   // [19:0] filtered, [31:20] out_row,
                                                         // [41:32] out_col, [47:42] zero
  output logic                                m_tlast,   // last_of_run
  output logic                                m_tuser,   // frame_done
  input  logic                                cfg_wr_en,
  input  logic [c3zp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [c3zp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import c3zp_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int COLX = (CW > OUT_COL_W) ? CW : OUT_COL_W;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  kernel_t                 kernel;

  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic [LIM_W-1:0] wlim;
  logic [LIM_W-1:0] hlim;
  logic             last_col;
  logic             last_row;
  logic             accept;
  lb_ctl_t          ctl;
  pos_t             pos;
  logic [COLX-1:0]  col_x;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_REG_W'(1024);
      image_height <= HEIGHT_REG_W'(1024);
      kernel       <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        CFG_KERNEL_TOP:   kernel[0]    <= cfg_data[KROW_W-1:0];
        CFG_KERNEL_MID:   kernel[1]    <= cfg_data[KROW_W-1:0];
        CFG_KERNEL_BOT:   kernel[2]    <= cfg_data[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // effective image size: zero acts as one, oversize is clamped
  always_comb begin
    wlim = LIM_W'(image_width);
    if (wlim == '0) begin
      wlim = LIM_W'(1);
    end else if (wlim > LIM_W'(MAX_WIDTH)) begin
      wlim = LIM_W'(MAX_WIDTH);
    end
    hlim = LIM_W'(image_height);
    if (hlim == '0) begin
      hlim = LIM_W'(1);
    end else if (hlim > LIM_W'(MAX_HEIGHT)) begin
      hlim = LIM_W'(MAX_HEIGHT);
    end
  end

  // a counter left past the end by a size change counts as the last index
  assign last_col = (LIM_W'(col) + LIM_W'(1)) >= wlim;
  assign last_row = (LIM_W'(row) + LIM_W'(1)) >= hlim;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  assign col_x = COLX'(col);

  always_comb begin
    ctl.row_ge1   = (row != '0);
    ctl.row_ge2   = (row > ROW_W'(1));
    ctl.first_col = (col == '0);
    pos.mask[SLOT_DIAG] = ctl.row_ge1 && !ctl.first_col;
    pos.mask[SLOT_UP]   = ctl.row_ge1 && last_col;
    pos.mask[SLOT_LEFT] = last_row && !ctl.first_col;
    pos.mask[SLOT_HERE] = last_row && last_col;
    pos.row_up   = row - ROW_W'(1);
    pos.row_cur  = row;
    pos.col_left = OUT_COL_W'(col_x - COLX'(1));
    pos.col_cur  = OUT_COL_W'(col_x);
  end

  logic  win_valid;
  logic  win_ready;
  win_t  win;
  pos_t  win_pos;
  logic  sum_valid;
  logic  sum_ready;
  sums_t sums;
  pos_t  sum_pos;

  c3zp_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_pix    (s_tdata[PIX_W-1:0]),
    .in_col    (col),
    .in_ctl    (ctl),
    .in_pos    (pos),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win),
    .win_pos   (win_pos)
  );

  c3zp_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (win_valid),
    .in_ready  (win_ready),
    .win       (win),
    .in_pos    (win_pos),
    .kernel    (kernel),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .sums      (sums),
    .out_pos   (sum_pos)
  );

  c3zp_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_sums   (sums),
    .in_pos    (sum_pos),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast),
    .out_flag  (m_tuser)
  );

endmodule
